// ----- src/brl_pkg.sv -----
// Package for the battery runtime learner.
// Holds controller state codes, command and status structs and fixed constants.
package brl_pkg;

    localparam int unsigned FULL_PROGRESS = 25600;
    localparam int unsigned RUNTIME_MAX   = 65535;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MIN_SESSION = 3'd0;
    localparam logic [2:0] CFG_MIN_DROP    = 3'd1;
    localparam logic [2:0] CFG_MIN_RUNTIME = 3'd2;
    localparam logic [2:0] CFG_MAX_RUNTIME = 3'd3;
    localparam logic [2:0] CFG_BLEND       = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_DIV_TIME,
        ST_DIV_DROP,
        ST_DIV_RUN,
        ST_UPDATE,
        ST_OUT
    } state_t;

    // Divider operand selection.
    typedef enum logic [1:0] {
        DIV_TIME,
        DIV_DROP,
        DIV_RUN
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     apply;
        logic     div_start;
        div_sel_t div_sel;
        logic     save_q;
        logic     update;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic finalize_learn;
    } status_t;

endpackage

// ----- src/brl_datapath.sv -----
// Datapath of the battery runtime learner: session state, shared divider, blend.
// Depends on brl_pkg for command and status types.
module brl_datapath #(
    parameter int TIME_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  brl_pkg::cmd_t        cmd,
    output brl_pkg::status_t     status,
    input  logic                 in_action,
    input  logic [14:0]          in_level,
    input  logic [TIME_BITS-1:0] in_now,
    input  logic                 in_completed,
    input  logic [31:0]          min_session_ms,
    input  logic [14:0]          min_drop,
    input  logic [15:0]          min_runtime,
    input  logic [15:0]          max_runtime,
    input  logic [8:0]           blend_weight,
    output logic [14:0]          learn_progress,
    output logic [15:0]          observed_runtime,
    output logic                 runtime_updated,
    output logic [15:0]          learned_runtime,
    output logic                 learned_valid,
    output logic [15:0]          learned_count
);
    localparam int NB = TIME_BITS + 16;
    localparam int CW = $clog2(NB + 1);

    logic                 open_reg;
    logic [14:0]          start_reg, last_reg;
    logic [TIME_BITS-1:0] elapsed_reg, stamp_reg;
    logic [15:0]          est_reg, count_reg;
    logic                 est_valid_reg;
    logic                 action_reg, completed_reg;
    logic [14:0]          level_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 learn_reg;
    logic [TIME_BITS-1:0] fin_elapsed_reg;
    logic [14:0]          fin_drop_reg;
    logic [15:0]          tp_reg;
    logic [15:0]          dp_reg;
    logic [16:0]          obs_reg;
    logic                 upd_reg;

    // Divider registers.
    logic [NB-1:0] quo_reg, rem_reg;
    logic [NB-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;

    logic [14:0] drop_now;
    logic [15:0] sdrop;
    logic [NB-1:0] elapsed_ext;
    logic        learn_ok;
    logic [8:0]  w;
    logic [24:0] blend_sum;

    assign drop_now    = (start_reg > last_reg) ? 15'(start_reg - last_reg) : 15'd0;
    assign sdrop       = {1'b0, fin_drop_reg};
    assign elapsed_ext = NB'(elapsed_reg);

    // A finalize of an open, completed session learns when it ran long enough and dropped far enough.
    assign learn_ok = action_reg && open_reg && completed_reg
                      && (NB'(elapsed_reg) >= NB'(min_session_ms))
                      && (start_reg >= last_reg)
                      && (15'(start_reg - last_reg) >= min_drop);

    assign status.div_busy       = busy_reg;
    assign status.finalize_learn = learn_reg;

    // Shared restoring divider, one quotient bit per cycle.
    logic [NB:0] trial;
    assign trial = {rem_reg, quo_reg[NB-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NB);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            case (cmd.div_sel)
                brl_pkg::DIV_TIME:
                begin
                    // Times 25600 as 16384 + 8192 + 1024.
                    quo_reg <= (elapsed_ext << 14) + (elapsed_ext << 13) + (elapsed_ext << 10);
                    den_reg <= NB'(min_session_ms);
                end
                brl_pkg::DIV_DROP:
                begin
                    quo_reg <= NB'(drop_now) * NB'(brl_pkg::FULL_PROGRESS);
                    den_reg <= NB'(min_drop);
                end
                default:
                begin
                    quo_reg <= NB'(fin_elapsed_reg) << 13;
                    den_reg <= NB'(sdrop * 16'd4500 > 0 ? 32'(sdrop) * 32'd4500 : 32'd1);
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (!trial[NB])
            begin
                rem_reg <= trial[NB-1:0];
                quo_reg <= {quo_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[NB-2:0], quo_reg[NB-1]};
                quo_reg <= {quo_reg[NB-2:0], 1'b0};
            end
        end
    end

    // Blend of the new observation with the held estimate.
    assign w = (blend_weight > 9'd256) ? 9'd256 : blend_weight;
    assign blend_sum = 25'(w) * 25'(quo_reg[15:0])
                       + 25'(9'd256 - w) * 25'(est_reg) + 25'd128;

    // Session state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            start_reg     <= '0;
            last_reg      <= '0;
            elapsed_reg   <= '0;
            stamp_reg     <= '0;
            est_reg       <= '0;
            est_valid_reg <= 1'b0;
            count_reg     <= '0;
            learn_reg     <= 1'b0;
            upd_reg       <= 1'b0;
            obs_reg       <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                upd_reg <= 1'b0;
                obs_reg <= '0;
            end
            if (cmd.apply)
            begin
                learn_reg <= learn_ok;
                if (!action_reg)
                begin
                    if (!open_reg)
                    begin
                        open_reg    <= 1'b1;
                        start_reg   <= level_reg;
                        last_reg    <= level_reg;
                        elapsed_reg <= '0;
                        stamp_reg   <= now_reg;
                    end
                    else
                    begin
                        if (stamp_reg != '0)
                        begin
                            elapsed_reg <= elapsed_reg + (now_reg - stamp_reg);
                            stamp_reg   <= now_reg;
                        end
                        last_reg <= level_reg;
                    end
                end
                else if (open_reg)
                begin
                    open_reg    <= 1'b0;
                    start_reg   <= '0;
                    last_reg    <= '0;
                    elapsed_reg <= '0;
                    stamp_reg   <= '0;
                end
            end
            if (cmd.update && learn_reg)
            begin
                if (fin_drop_reg == '0)
                begin
                    obs_reg <= 17'(brl_pkg::RUNTIME_MAX);
                end
                else
                begin
                    obs_reg <= (quo_reg > NB'(brl_pkg::RUNTIME_MAX))
                        ? 17'h10000 : 17'(quo_reg);
                    if (quo_reg >= NB'(min_runtime) && quo_reg <= NB'(max_runtime))
                    begin
                        est_reg       <= est_valid_reg ? blend_sum[23:8] : quo_reg[15:0];
                        est_valid_reg <= 1'b1;
                        if (count_reg != 16'hFFFF)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        upd_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Payload captures.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg    <= in_action;
            level_reg     <= in_level;
            now_reg       <= in_now;
            completed_reg <= in_completed;
        end
        if (cmd.apply)
        begin
            fin_elapsed_reg <= elapsed_reg;
            fin_drop_reg    <= drop_now;
        end
        if (cmd.save_q)
        begin
            if (cmd.div_sel == brl_pkg::DIV_TIME)
            begin
                tp_reg <= (min_session_ms == '0 || quo_reg > NB'(brl_pkg::FULL_PROGRESS))
                    ? 16'(brl_pkg::FULL_PROGRESS) : quo_reg[15:0];
            end
            else
            begin
                dp_reg <= (min_drop == '0 || quo_reg > NB'(brl_pkg::FULL_PROGRESS))
                    ? 16'(brl_pkg::FULL_PROGRESS) : quo_reg[15:0];
            end
        end
    end

    // Result fields.
    assign learn_progress   = !open_reg ? 15'd0
                              : (tp_reg < dp_reg ? tp_reg[14:0] : dp_reg[14:0]);
    assign observed_runtime = obs_reg[16] ? 16'hFFFF : obs_reg[15:0];
    assign runtime_updated  = upd_reg;
    assign learned_runtime  = est_reg;
    assign learned_valid    = est_valid_reg;
    assign learned_count    = count_reg;
endmodule

// ----- src/brl_controller.sv -----
// Controller state machine of the battery runtime learner.
// Depends on brl_pkg for state, command and status types.
module brl_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    output logic             in_ready,
    output logic             out_valid,
    output brl_pkg::cmd_t    cmd,
    input  brl_pkg::status_t status
);
    brl_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence: apply, runtime divide and update (only for a finalize that learns), progress divides, present.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = brl_pkg::DIV_TIME;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        case (state_reg)
            brl_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_fire;
                if (in_fire)
                begin
                    state_next = brl_pkg::ST_APPLY;
                end
            end
            brl_pkg::ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = brl_pkg::ST_DIV_RUN;
            end
            brl_pkg::ST_DIV_RUN:
            begin
                cmd.div_sel = brl_pkg::DIV_RUN;
                if (!status.finalize_learn)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = brl_pkg::DIV_TIME;
                    state_next    = brl_pkg::ST_DIV_TIME;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = brl_pkg::ST_UPDATE;
                end
            end
            brl_pkg::ST_UPDATE:
            begin
                if (!status.div_busy)
                begin
                    cmd.update    = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = brl_pkg::ST_DIV_TIME;
                end
            end
            brl_pkg::ST_DIV_TIME:
            begin
                if (!status.div_busy)
                begin
                    cmd.save_q    = 1'b1;
                    state_next    = brl_pkg::ST_DIV_DROP;
                end
            end
            brl_pkg::ST_DIV_DROP:
            begin
                cmd.div_sel   = brl_pkg::DIV_DROP;
                cmd.div_start = 1'b1;
                state_next    = brl_pkg::ST_OUT;
            end
            brl_pkg::ST_OUT:
            begin
                // The last cycle of a request is flagged as done.
                cmd.div_sel = brl_pkg::DIV_DROP;
                if (!status.div_busy)
                begin
                    cmd.save_q = 1'b1;
                    out_valid  = 1'b1;
                    state_next = brl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brl_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// ----- src/battery_runtime_learner.sv -----
// Top level of the battery runtime learner: stream ports, config registers, output stage.
// Depends on brl_pkg, brl_controller and brl_datapath.
//
// channel   | signals                       | contents
// s_axis    | tvalid tready tdata tuser     | request: level, time, completed; action
// m_axis    | tvalid tready tdata           | result fields
// cfg       | cfg_we cfg_index cfg_data     | threshold and blend registers
//
// The shared bit-per-cycle divider runs two times per request, or three times for a
// finalize that learns.
// rst_n clears session state, the learned model and loads register defaults.
// The result waits in an output register; the next request is accepted meanwhile.
// Input stalls while a request is in work, and after it only when a second result
// is finished while the first still waits.
module battery_runtime_learner #(
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // battery_level[14:0], now_ms[46:15], completed[47]
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // learn_progress, observed_runtime, runtime_updated,
                                        // learned_runtime, learned_valid, learned_count
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [31:0] min_session_reg;
    logic [14:0] min_drop_reg;
    logic [15:0] min_runtime_reg, max_runtime_reg;
    logic [8:0]  blend_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_session_reg <= 32'd7200000;
            min_drop_reg    <= 15'd2048;
            min_runtime_reg <= 16'd1280;
            max_runtime_reg <= 16'd51200;
            blend_reg       <= 9'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                brl_pkg::CFG_MIN_SESSION: min_session_reg <= cfg_data;
                brl_pkg::CFG_MIN_DROP:    min_drop_reg    <= cfg_data[14:0];
                brl_pkg::CFG_MIN_RUNTIME: min_runtime_reg <= cfg_data[15:0];
                brl_pkg::CFG_MAX_RUNTIME: max_runtime_reg <= cfg_data[15:0];
                brl_pkg::CFG_BLEND:       blend_reg       <= cfg_data[8:0];
                default:                  ;
            endcase
        end
    end

    brl_pkg::cmd_t    cmd;
    brl_pkg::status_t status;
    logic             core_ready, core_done;
    logic             in_fire;
    logic [14:0]      lp;
    logic [15:0]      obs, lr, lc;
    logic             mu, lv;
    logic             out_full_reg;
    logic [64:0]      out_data_reg;
    logic             pending_reg;

    assign s_axis_tready = core_ready && !pending_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    brl_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_ready  (core_ready),
        .out_valid (core_done),
        .cmd       (cmd),
        .status    (status)
    );

    brl_datapath #(.TIME_BITS(TIME_BITS)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_action        (s_axis_tuser),
        .in_level         (s_axis_tdata[14:0]),
        .in_now           (TIME_BITS'(s_axis_tdata[46:15])),
        .in_completed     (s_axis_tdata[47]),
        .min_session_ms   (min_session_reg),
        .min_drop         (min_drop_reg),
        .min_runtime      (min_runtime_reg),
        .max_runtime      (max_runtime_reg),
        .blend_weight     (blend_reg),
        .learn_progress   (lp),
        .observed_runtime (obs),
        .runtime_updated  (mu),
        .learned_runtime  (lr),
        .learned_valid    (lv),
        .learned_count    (lc)
    );

    // A request is done when the controller returns to idle after working on it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                pending_reg <= 1'b1;
            end
            else if (pending_reg && core_ready && !out_full_reg)
            begin
                pending_reg  <= 1'b0;
                out_full_reg <= 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pending_reg && core_ready && !out_full_reg)
        begin
            out_data_reg <= {lc, lv, lr, mu, obs, lp};
        end
    end

    assign m_axis_tvalid = out_full_reg;
    assign m_axis_tdata  = {7'b0, out_data_reg};

    // The block never takes a request while an earlier one is in progress or not yet in the output register.
    assert property (@(posedge clk) disable iff (!rst_n) pending_reg |-> !s_axis_tready)
        else $error("request accepted while one is in progress");
    // A held result stays stable until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // The divider is never busy at an accept.
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |-> !status.div_busy)
        else $error("divider busy at accept");
    // The controller only finishes a request that is in progress.
    assert property (@(posedge clk) disable iff (!rst_n) core_done |-> pending_reg)
        else $error("controller finished without a request");
endmodule

// ----- tb/tb_battery_runtime_learner.sv -----
// Self-checking testbench for battery_runtime_learner: directed and random discharge sessions.
// Each result is checked against a behavioral predictor of the learner.
// Depends on brl_pkg and the battery_runtime_learner RTL.
`timescale 1ns / 100ps

module tb_battery_runtime_learner;

    localparam logic ACT_SAMPLE   = 1'b0;
    localparam logic ACT_FINALIZE = 1'b1;
    localparam int   SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [15:0] learned_count;
        logic        learned_valid;
        logic [15:0] learned_runtime;
        logic        runtime_updated;
        logic [15:0] observed_runtime;
        logic [14:0] learn_progress;
    } learn_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // battery_level[14:0], now_ms[46:15], completed[47]
    logic        s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // learn_progress, observed_runtime, runtime_updated,
                                 // learned_runtime, learned_valid, learned_count
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // Predictor copy of the registers.
    logic [31:0] thr_session_ms;
    logic [14:0] thr_drop;
    logic [15:0] thr_runtime_lo;
    logic [15:0] thr_runtime_hi;
    logic [8:0]  mix_weight;

    // Predictor copy of the learner state.
    logic        sess_active;
    logic [14:0] sess_start_level;
    logic [14:0] sess_last_level;
    logic [31:0] sess_elapsed;
    logic [31:0] sess_stamp;
    logic [15:0] model_runtime;
    logic        model_valid;
    logic [15:0] model_sessions;

    learn_result_t expected_results[$];
    int            error_count;
    int            accepted_requests;
    int            burst_left;
    logic          hold_results;
    int            ready_mode;
    int            ready_cycle;

    battery_runtime_learner u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Progress toward a learnable session, taken from the current state.
    function automatic logic [14:0] session_progress();
        logic [63:0] time_part;
        logic [63:0] drop_part;
        logic [63:0] level_drop;
        if (!sess_active)
            return '0;
        level_drop = (sess_start_level > sess_last_level) ?
                     64'(sess_start_level - sess_last_level) : 64'd0;
        if (thr_session_ms == 0)
            time_part = brl_pkg::FULL_PROGRESS;
        else
            time_part = (64'(sess_elapsed) * brl_pkg::FULL_PROGRESS) / thr_session_ms;
        if (time_part > brl_pkg::FULL_PROGRESS)
            time_part = brl_pkg::FULL_PROGRESS;
        if (thr_drop == 0)
            drop_part = brl_pkg::FULL_PROGRESS;
        else
            drop_part = (level_drop * brl_pkg::FULL_PROGRESS) / thr_drop;
        if (drop_part > brl_pkg::FULL_PROGRESS)
            drop_part = brl_pkg::FULL_PROGRESS;
        return (time_part < drop_part) ? time_part[14:0] : drop_part[14:0];
    endfunction

    // Applies one request to the predicted state and returns the expected result.
    function automatic learn_result_t predict_learning(logic action, logic [14:0] level,
                                                       logic [31:0] now_ms, logic completed);
        learn_result_t res;
        int            drop;
        logic [63:0]   raw;
        logic [63:0]   sum;
        logic [8:0]    w;
        res = '0;
        if (action == ACT_SAMPLE)
        begin
            if (!sess_active)
            begin
                sess_active      = 1'b1;
                sess_start_level = level;
                sess_last_level  = level;
                sess_elapsed     = '0;
                sess_stamp       = now_ms;
            end
            else
            begin
                // A zero stamp freezes the elapsed time.
                if (sess_stamp != 0)
                begin
                    sess_elapsed = sess_elapsed + (now_ms - sess_stamp);
                    sess_stamp   = now_ms;
                end
                sess_last_level = level;
            end
        end
        else if (sess_active)
        begin
            drop = int'(sess_start_level) - int'(sess_last_level);
            if (completed && sess_elapsed >= thr_session_ms && drop >= int'(thr_drop))
            begin
                if (drop == 0)
                begin
                    res.observed_runtime = 16'hFFFF;
                end
                else
                begin
                    raw = (64'(sess_elapsed) * 8192) / (64'd4500 * 64'(drop));
                    res.observed_runtime = (raw > 65535) ? 16'hFFFF : raw[15:0];
                    if (raw >= thr_runtime_lo && raw <= thr_runtime_hi)
                    begin
                        if (model_valid)
                        begin
                            w   = (mix_weight > 256) ? 9'd256 : mix_weight;
                            sum = 64'(w) * raw + 64'(256 - w) * model_runtime + 128;
                            model_runtime = sum[23:8];
                        end
                        else
                        begin
                            model_runtime = raw[15:0];
                        end
                        model_valid = 1'b1;
                        if (model_sessions != 16'hFFFF)
                            model_sessions = model_sessions + 16'd1;
                        res.runtime_updated = 1'b1;
                    end
                end
            end
            sess_active      = 1'b0;
            sess_elapsed     = '0;
            sess_start_level = '0;
            sess_last_level  = '0;
            sess_stamp       = '0;
        end
        res.learn_progress  = session_progress();
        res.learned_runtime = model_runtime;
        res.learned_valid   = model_valid;
        res.learned_count   = model_sessions;
        return res;
    endfunction

    // Sends one request in bursts with random gaps, then records its expected result.
    task automatic send_request(logic action, logic [14:0] level, logic [31:0] now_ms,
                                logic completed);
        @(negedge clk);
        if (burst_left <= 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tdata  <= {completed, now_ms, level};
        s_axis_tuser  <= action;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_results.push_back(predict_learning(action, level, now_ms, completed));
        accepted_requests++;
        burst_left--;
    endtask

    // Waits until every result is back and the block has settled.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] index, logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (index)
            brl_pkg::CFG_MIN_SESSION: thr_session_ms = value;
            brl_pkg::CFG_MIN_DROP:    thr_drop       = value[14:0];
            brl_pkg::CFG_MIN_RUNTIME: thr_runtime_lo = value[15:0];
            brl_pkg::CFG_MAX_RUNTIME: thr_runtime_hi = value[15:0];
            brl_pkg::CFG_BLEND:       mix_weight     = value[8:0];
            default: ;
        endcase
    endtask

    task automatic write_all_registers(logic [31:0] sess_ms, logic [31:0] drop,
                                       logic [31:0] lo, logic [31:0] hi, logic [31:0] w);
        wait_idle();
        write_register(brl_pkg::CFG_MIN_SESSION, sess_ms);
        write_register(brl_pkg::CFG_MIN_DROP, drop);
        write_register(brl_pkg::CFG_MIN_RUNTIME, lo);
        write_register(brl_pkg::CFG_MAX_RUNTIME, hi);
        write_register(brl_pkg::CFG_BLEND, w);
    endtask

    // Directed cases: lone finalize, zero stamp, wrapping time, field extremes, learning.
    task automatic test_directed();
        send_request(ACT_FINALIZE, 15'd0, 32'd0, 1'b1);
        send_request(ACT_SAMPLE, 15'd25600, 32'd0, 1'b0);
        send_request(ACT_SAMPLE, 15'd100, 32'd9000000, 1'b0);
        send_request(ACT_FINALIZE, 15'h7FFF, 32'hFFFFFFFF, 1'b1);
        send_request(ACT_SAMPLE, 15'd25600, 32'd1000, 1'b0);
        send_request(ACT_SAMPLE, 15'd23552, 32'd7201000, 1'b0);
        send_request(ACT_FINALIZE, 15'd0, 32'd0, 1'b1);
        send_request(ACT_SAMPLE, 15'd20000, 32'hFF000000, 1'b0);
        send_request(ACT_SAMPLE, 15'd17000, 32'd8000000, 1'b1);
        send_request(ACT_FINALIZE, 15'd0, 32'd0, 1'b1);
        send_request(ACT_SAMPLE, 15'd25600, 32'd5, 1'b0);
        send_request(ACT_SAMPLE, 15'd20000, 32'd9000005, 1'b0);
        send_request(ACT_FINALIZE, 15'd0, 32'd0, 1'b0);
        send_request(ACT_SAMPLE, 15'h7FFF, 32'h80000000, 1'b0);
        send_request(ACT_SAMPLE, 15'h7FFF, 32'h7FFFFFFF, 1'b0);
        send_request(ACT_SAMPLE, 15'd0, 32'hFFFFFFFF, 1'b0);
        send_request(ACT_FINALIZE, 15'd0, 32'd0, 1'b1);
        send_request(ACT_SAMPLE, 15'd10, 32'd1, 1'b0);
        send_request(ACT_SAMPLE, 15'd500, 32'd20000000, 1'b0);
        send_request(ACT_FINALIZE, 15'd0, 32'd0, 1'b1);
    endtask

    // Random sessions scaled to the thresholds, mixed with unstructured requests.
    task automatic test_random_sessions(int request_budget);
        int          sent;
        int          samples;
        logic [63:0] base_ms;
        logic [63:0] total_ms;
        logic [63:0] total_drop;
        logic [31:0] now_ms;
        logic [14:0] level;
        sent = 0;
        while (sent < request_budget)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_request(1'($urandom), 15'($urandom), $urandom, 1'($urandom));
                sent++;
            end
            else
            begin
                base_ms = (thr_session_ms > 32'h40000000 || thr_session_ms == 0) ?
                          64'h40000000 : 64'(thr_session_ms);
                if (thr_session_ms == 0)
                    base_ms = $urandom_range(1000, 10000000);
                total_ms   = base_ms * $urandom_range(40, 300) / 100;
                total_drop = 64'(thr_drop == 0 ? 15'd2048 : thr_drop) *
                             $urandom_range(0, 400) / 100;
                samples    = $urandom_range(1, 4);
                level      = (total_drop > 25600) ? 15'h7FFF : 15'($urandom_range(25600, 32767));
                if ($urandom_range(0, 3) == 0)
                    level = 15'($urandom_range(int'(total_drop), 25600));
                now_ms = $urandom;
                if (now_ms == 0)
                    now_ms = 32'd1;
                send_request(ACT_SAMPLE, level, now_ms, 1'($urandom));
                sent++;
                for (int i = 0; i < samples; i++)
                begin
                    now_ms = now_ms + 32'(total_ms / samples);
                    level  = 15'(int'(level) - int'(total_drop / samples));
                    send_request(ACT_SAMPLE, level, now_ms, 1'($urandom));
                    sent++;
                end
                send_request(ACT_FINALIZE, 15'($urandom), $urandom, $urandom_range(0, 9) != 0);
                sent++;
            end
        end
    endtask

    // Threshold extremes: least, greatest and zero settings, then a random setting.
    task automatic test_register_settings();
        write_all_registers(32'd1, 32'd1, 32'd0, 32'd65534, 32'd256);
        test_random_sessions(80);
        write_all_registers(32'hFFFFFFFF, 32'd25600, 32'd65534, 32'd65534, 32'd0);
        test_random_sessions(50);
        write_all_registers(32'd0, 32'd0, 32'd100, 32'd30000, 32'd128);
        send_request(ACT_SAMPLE, 15'd9000, 32'd77, 1'b0);
        send_request(ACT_SAMPLE, 15'd9000, 32'd5000, 1'b0);
        send_request(ACT_FINALIZE, 15'd0, 32'd0, 1'b1);
        test_random_sessions(40);
        write_all_registers($urandom_range(1000, 20000000), $urandom_range(1, 25600),
                            $urandom_range(0, 4000), $urandom_range(4000, 65534),
                            $urandom_range(0, 256));
        test_random_sessions(100);
    endtask

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        learn_result_t got;
        learn_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[64:0];
            if (expected_results.size() == 0)
            begin
                $error("unexpected result %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.learn_progress !== want.learn_progress)
                begin
                    $error("learn_progress exp %0d got %0d", want.learn_progress,
                           got.learn_progress);
                    error_count++;
                end
                if (got.observed_runtime !== want.observed_runtime)
                begin
                    $error("observed_runtime exp %0d got %0d", want.observed_runtime,
                           got.observed_runtime);
                    error_count++;
                end
                if (got.runtime_updated !== want.runtime_updated)
                begin
                    $error("runtime_updated exp %0d got %0d", want.runtime_updated,
                           got.runtime_updated);
                    error_count++;
                end
                if (got.learned_runtime !== want.learned_runtime)
                begin
                    $error("learned_runtime exp %0d got %0d", want.learned_runtime,
                           got.learned_runtime);
                    error_count++;
                end
                if (got.learned_valid !== want.learned_valid)
                begin
                    $error("learned_valid exp %0d got %0d", want.learned_valid,
                           got.learned_valid);
                    error_count++;
                end
                if (got.learned_count !== want.learned_count)
                begin
                    $error("learned_count exp %0d got %0d", want.learned_count,
                           got.learned_count);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern with a randomly chosen mode.
    always @(negedge clk)
    begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle % 64 == 0)
            ready_mode <= $urandom_range(0, 2);
        if (hold_results)
            m_axis_tready <= 1'b0;
        else if (ready_mode == 0)
            m_axis_tready <= 1'b1;
        else if (ready_mode == 1)
            m_axis_tready <= $urandom_range(0, 1);
        else
            m_axis_tready <= ($urandom_range(0, 9) < 2);
    end

    // Long receiver hold-off while the sender keeps offering requests.
    initial
    begin
        hold_results = 1'b0;
        wait (accepted_requests >= 60);
        @(negedge clk);
        hold_results = 1'b1;
        repeat (2000) @(posedge clk);
        @(negedge clk);
        hold_results = 1'b0;
    end

    // Main sequence.
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_SAMPLE;
        m_axis_tready  = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = brl_pkg::CFG_MIN_SESSION;
        cfg_data       = '0;
        ready_mode     = 0;
        ready_cycle    = 0;
        error_count    = 0;
        accepted_requests = 0;
        burst_left     = 0;
        thr_session_ms = 32'd7200000;
        thr_drop       = 15'd2048;
        thr_runtime_lo = 16'd1280;
        thr_runtime_hi = 16'd51200;
        mix_weight     = 9'd64;
        sess_active    = 1'b0;
        sess_start_level = '0;
        sess_last_level  = '0;
        sess_elapsed   = '0;
        sess_stamp     = '0;
        model_runtime  = '0;
        model_valid    = 1'b0;
        model_sessions = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_sessions(150);
        test_register_settings();
        wait_idle();

        if (error_count == 0)
            $display("tb_battery_runtime_learner: PASS");
        else
            $display("tb_battery_runtime_learner: FAIL");
        $finish;
    end

    // Run limit.
    initial
    begin
        #20_000_000;
        $display("tb_battery_runtime_learner: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/brl_pkg.sv
src/brl_datapath.sv
src/brl_controller.sv
src/battery_runtime_learner.sv
tb/tb_battery_runtime_learner.sv
